@@ hw/rtl/nbht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbht_pkg
// Shared types and constants for the neighborhood bitmap hash table.
// ----------------------------------------------------------------------------
package nbht_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int NBHD_DEF  = 64;

    localparam int FUNC_W = 3;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int CNT_W  = 11;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_GET     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUT     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REPLACE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ADD     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd4;

    typedef struct packed {
        logic             live;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MAP,
        ST_PROBE,
        ST_PCHK,
        ST_PEND,
        ST_SCAN,
        ST_SCHK,
        ST_ACT,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/nbht_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbht request / response channels
// Valid/ready channels carrying table requests and their results.
// ----------------------------------------------------------------------------
interface nbht_req_if;
    logic                        valid;
    logic                        ready;
    logic [nbht_pkg::FUNC_W-1:0] func;
    logic [nbht_pkg::KEY_W-1:0]  key;
    logic [nbht_pkg::VAL_W-1:0]  value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

interface nbht_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [nbht_pkg::VAL_W-1:0] old_value;
    logic                       status;
    logic [nbht_pkg::CNT_W-1:0] live_count;

    modport source (output valid, found, old_value, status, live_count, input ready);
    modport sink   (input valid, found, old_value, status, live_count, output ready);
endinterface

@@ hw/rtl/nbht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbht_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module nbht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/neighborhood_bitmap_hash_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighborhood_bitmap_hash_table
// Hopscotch-style hash table with per-home neighborhood bitmaps.
// ----------------------------------------------------------------------------
// One request is worked at a time. After reset the block sweeps both memories
// to zero, one slot per cycle, through all SLOTS slots (1024 by default), and
// accepts no request until done. A request then visits the neighborhood
// offsets in the probe, with a read of the slot memory for each marked offset,
// and an insert that finds no match goes on to scan the slots after the highest
// marked offset. A zero key or an unused operation code ends without a probe,
// a hit on a marked offset ends the probe there, and for a key that is not
// marked every offset is probed. The single read port of the slot memory sets
// the pace of the probe and the scan. The result sits in an output register,
// so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module neighborhood_bitmap_hash_table #(
    parameter int SLOTS        = nbht_pkg::SLOTS_DEF,
    parameter int NEIGHBORHOOD = nbht_pkg::NBHD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nbht_req_if.sink   i_req,
    nbht_rsp_if.source o_rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int OW = $clog2(NEIGHBORHOOD);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = $bits(nbht_pkg::t_slot);
    localparam logic [OW-1:0] OFF_MAX = OW'(NEIGHBORHOOD - 1);

    nbht_pkg::t_state r_state, n_state;

    // request latch
    logic [nbht_pkg::FUNC_W-1:0] r_func, n_func;
    logic [nbht_pkg::KEY_W-1:0]  r_key, n_key;
    logic [nbht_pkg::VAL_W-1:0]  r_value, n_value;
    logic [AW-1:0]               r_home, n_home;

    // walk state: current offset, one past the highest marked offset, slot
    logic [OW-1:0] r_off, n_off;
    logic [OW:0]   r_last, n_last;
    logic [AW-1:0] r_addr, n_addr;

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_clr, n_clr;

    // pending result
    logic                       r_found, n_found;
    logic [nbht_pkg::VAL_W-1:0] r_old, n_old;
    logic                       r_status, n_status;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic                       r_o_found, n_o_found;
    logic [nbht_pkg::VAL_W-1:0] r_o_old, n_o_old;
    logic                       r_o_status, n_o_status;
    logic [nbht_pkg::CNT_W-1:0] r_o_count, n_o_count;

    // memory ports
    logic                  s_we, s_re, b_we, b_re;
    logic [AW-1:0]         s_waddr, s_raddr, b_waddr, b_raddr;
    nbht_pkg::t_slot       s_wdata, s_q;
    logic [SW-1:0]         s_q_raw;
    logic [NEIGHBORHOOD-1:0] b_wdata, b_q;

    logic [AW-1:0] walk_addr;
    logic          is_ins;

    // slot words: live bit, reserved key, value
    nbht_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_q_raw)
    );

    // neighborhood bitmaps, one per home slot
    nbht_ram #(.WIDTH(NEIGHBORHOOD), .DEPTH(SLOTS)) u_bmap_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    assign s_q       = nbht_pkg::t_slot'(s_q_raw);
    assign walk_addr = r_home + AW'(r_off);
    assign is_ins    = (r_func == nbht_pkg::FN_PUT) || (r_func == nbht_pkg::FN_ADD);

    assign i_req.ready      = (r_state == nbht_pkg::ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_o_found;
    assign o_rsp.old_value  = r_o_old;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.live_count = r_o_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nbht_pkg::ST_CLR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_value    <= n_value;
        r_home     <= n_home;
        r_off      <= n_off;
        r_last     <= n_last;
        r_addr     <= n_addr;
        r_found    <= n_found;
        r_old      <= n_old;
        r_status   <= n_status;
        r_o_found  <= n_o_found;
        r_o_old    <= n_o_old;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_value     = r_value;
        n_home      = r_home;
        n_off       = r_off;
        n_last      = r_last;
        n_addr      = r_addr;
        n_count     = r_count;
        n_clr       = r_clr;
        n_found     = r_found;
        n_old       = r_old;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_o_found   = r_o_found;
        n_o_old     = r_o_old;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;

        s_we    = 1'b0;
        s_waddr = r_addr;
        s_wdata = '0;
        s_re    = 1'b0;
        s_raddr = walk_addr;
        b_we    = 1'b0;
        b_waddr = r_home;
        b_wdata = '0;
        b_re    = 1'b0;
        b_raddr = r_home;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            nbht_pkg::ST_CLR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                b_we    = 1'b1;
                b_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = nbht_pkg::ST_IDLE;
                end
            end
            nbht_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_key   = i_req.key;
                    n_value = i_req.value;
                    n_home  = i_req.key[AW-1:0];
                    b_re    = 1'b1;
                    b_raddr = i_req.key[AW-1:0];
                    n_off   = '0;
                    n_last  = '0;
                    n_state = nbht_pkg::ST_MAP;
                end
            end
            nbht_pkg::ST_MAP: begin
                n_found  = 1'b0;
                n_old    = '0;
                n_status = 1'b0;
                if (r_func > nbht_pkg::FN_REMOVE) begin
                    n_state = nbht_pkg::ST_DONE;
                end else if (r_key == '0) begin
                    n_status = is_ins;
                    n_state  = nbht_pkg::ST_DONE;
                end else begin
                    n_state = nbht_pkg::ST_PROBE;
                end
            end
            nbht_pkg::ST_PROBE: begin
                if (b_q[r_off]) begin
                    s_re    = 1'b1;
                    n_addr  = walk_addr;
                    n_last  = {1'b0, r_off} + (OW + 1)'(1);
                    n_state = nbht_pkg::ST_PCHK;
                end else if (r_off == OFF_MAX) begin
                    n_state = nbht_pkg::ST_PEND;
                end else begin
                    n_off = r_off + OW'(1);
                end
            end
            nbht_pkg::ST_PCHK: begin
                if (s_q.key == r_key) begin
                    n_state = nbht_pkg::ST_ACT;
                end else if (r_off == OFF_MAX) begin
                    n_state = nbht_pkg::ST_PEND;
                end else begin
                    n_off   = r_off + OW'(1);
                    n_state = nbht_pkg::ST_PROBE;
                end
            end
            nbht_pkg::ST_PEND: begin
                if (!is_ins) begin
                    n_state = nbht_pkg::ST_DONE;
                end else if (r_last == (OW + 1)'(NEIGHBORHOOD)) begin
                    n_status = 1'b1;
                    n_state  = nbht_pkg::ST_DONE;
                end else begin
                    n_off   = r_last[OW-1:0];
                    n_state = nbht_pkg::ST_SCAN;
                end
            end
            nbht_pkg::ST_SCAN: begin
                s_re    = 1'b1;
                n_addr  = walk_addr;
                n_state = nbht_pkg::ST_SCHK;
            end
            nbht_pkg::ST_SCHK: begin
                if (s_q.key == '0) begin
                    // reserve the free slot and mark it in the home bitmap
                    s_we          = 1'b1;
                    s_wdata.live  = 1'b1;
                    s_wdata.key   = r_key;
                    s_wdata.value = r_value;
                    b_we          = 1'b1;
                    b_wdata       = b_q | (NEIGHBORHOOD'(1) << r_off);
                    n_count       = r_count + CW'(1);
                    n_state       = nbht_pkg::ST_DONE;
                end else if (s_q.key == r_key) begin
                    n_state = nbht_pkg::ST_ACT;
                end else if (r_off == OFF_MAX) begin
                    n_status = 1'b1;
                    n_state  = nbht_pkg::ST_DONE;
                end else begin
                    n_off   = r_off + OW'(1);
                    n_state = nbht_pkg::ST_SCAN;
                end
            end
            nbht_pkg::ST_ACT: begin
                s_wdata.key   = r_key;
                s_wdata.live  = 1'b1;
                s_wdata.value = r_value;
                if (s_q.live) begin
                    n_found = 1'b1;
                    n_old   = s_q.value;
                end
                case (r_func)
                    nbht_pkg::FN_REPLACE: begin
                        s_we = s_q.live;
                    end
                    nbht_pkg::FN_REMOVE: begin
                        s_wdata.live  = 1'b0;
                        s_wdata.value = s_q.value;
                        s_we          = s_q.live;
                        if (s_q.live && r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    nbht_pkg::FN_PUT: begin
                        s_we = 1'b1;
                        if (!s_q.live) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    nbht_pkg::FN_ADD: begin
                        s_we = !s_q.live;
                        if (!s_q.live) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = nbht_pkg::ST_DONE;
            end
            nbht_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_old     = r_old;
                    n_o_status  = r_status;
                    n_o_count   = nbht_pkg::CNT_W'(r_count);
                    n_state     = nbht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nbht_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nbht_pkg::ST_CLR) |-> !i_req.ready)
        else $error("request taken during clearing sweep");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("live count above table size");

    a_refused_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status) |-> !r_o_found)
        else $error("refused insert reports a found entry");

    a_accept_to_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == nbht_pkg::ST_MAP))
        else $error("accepted request did not start bitmap read");
`endif

endmodule
